[hw/rtl/pem_pkg.sv]
// ----------------------------------------------------------------------------
// pem_pkg
// Shared types, constants and tables of the pose error metric pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package pem_pkg;

    // number formats
    localparam int ROT_FRAC_BITS   = 16;
    localparam int TRANS_FRAC_BITS = 12;
    localparam int ROT_W           = ROT_FRAC_BITS + 2;
    localparam int TRANS_W         = TRANS_FRAC_BITS + 8;

    // stream field widths
    localparam int ROW_W      = 54;
    localparam int TVEC_W     = 60;
    localparam int IN_BITS    = 6 * ROW_W + 2 * TVEC_W;
    localparam int IN_DATA_W  = ((IN_BITS + 7) / 8) * 8;
    localparam int NORM_W     = 40;
    localparam int ANGLE_W    = 24;
    localparam int STATUS_W   = 2;
    localparam int OUT_BITS   = NORM_W + ANGLE_W + STATUS_W;
    localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

    // configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_UNIT_DEGREES = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_CLAMP_TOL    = 1'b1;
    localparam logic [15:0]          TOL_RESET        = 16'd66;

    // datapath widths
    localparam int PT_W    = ROT_W + TRANS_W;          // rotation x translation
    localparam int PR_W    = 2 * ROT_W;                // rotation x rotation
    localparam int P_W     = PT_W + 3;                 // composed translation, exact
    localparam int TR_W    = PR_W + 4;                 // trace
    localparam int D_W     = TR_W + 1;
    localparam int Q_W     = P_W - ROT_FRAC_BITS;      // rounded translation
    localparam int SQ_W    = 2 * Q_W;
    localparam int NSUM_W  = SQ_W + 2;
    localparam int NORM_SHR = (2 * TRANS_FRAC_BITS >= 24) ? 2 * TRANS_FRAC_BITS - 24 : 0;
    localparam int NORM_SHL = (2 * TRANS_FRAC_BITS >= 24) ? 0 : 24 - 2 * TRANS_FRAC_BITS;
    localparam int COS_FB  = 2 * ROT_FRAC_BITS + 1;
    localparam int M_SHR   = (COS_FB >= 30) ? COS_FB - 30 : 0;
    localparam int M_SHL   = (COS_FB >= 30) ? 0 : 30 - COS_FB;
    localparam int TOL_SHL = COS_FB - 16;
    localparam int M_W     = 31;
    localparam int RAD_W   = 61;

    // square root and arctangent
    localparam int SQRT_STEPS   = 32;
    localparam int CORDIC_STEPS = 30;
    localparam int XY_W         = 35;
    localparam int Z_W          = 34;

    localparam logic [Z_W-1:0]  PI_Q30       = Z_W'(64'd3373259426);
    localparam logic [Z_W-1:0]  HALF_PI_Q30  = Z_W'(64'd1686629713);
    localparam logic [29:0]     DEG_PER_RAD  = 30'd961263669;
    localparam logic [ANGLE_W-1:0] ANGLE_MAX = 24'd11796480;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_HIGH = 2'd1,
        ST_LOW  = 2'd2
    } status_t;

    // where the final angle comes from
    typedef enum logic [1:0] {
        SRC_CORDIC = 2'd0,
        SRC_ZERO   = 2'd1,
        SRC_PI     = 2'd2
    } src_t;

    // per-request side data carried along the pipeline
    typedef struct packed {
        logic [NORM_W-1:0] norm;
        status_t           status;
        src_t              src;
        logic              neg;
    } side_t;

    // arctangent of 2^-i in Q30 radians
    function automatic logic [Z_W-1:0] atan_q30(input int i);
        logic [31:0] v;
        case (i)
            0:  v = 32'd843314857;
            1:  v = 32'd497837829;
            2:  v = 32'd263043837;
            3:  v = 32'd133525159;
            4:  v = 32'd67021687;
            5:  v = 32'd33543516;
            6:  v = 32'd16775851;
            7:  v = 32'd8388437;
            8:  v = 32'd4194283;
            9:  v = 32'd2097149;
            default: v = 32'd1 << (30 - i);
        endcase
        return Z_W'(v);
    endfunction

endpackage

`default_nettype wire

[hw/rtl/pose_error_metric.sv]
// ----------------------------------------------------------------------------
// pose_error_metric
// Composes two rigid poses and reports squared translation norm and angle.
// ----------------------------------------------------------------------------
// Stages from input request to result: 5 front stages, 32 square root
// stages, 30 CORDIC stages, 3 output stages.
// Throughput: one request per cycle; the whole pipeline halts while a result
// waits at the output.
// Reset: asynchronous, active low; clears valid bits and restores degrees
// output and a tolerance of 66.
`default_nettype none

module pose_error_metric (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    // fields from bit 0: rot_a_row0..2, rot_b_row0..2, trans_a, trans_b
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [pem_pkg::IN_DATA_W-1:0]  s_tdata,
    // fields from bit 0: trans_sq_norm, rot_angle, status
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [pem_pkg::OUT_DATA_W-1:0]      m_tdata,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [pem_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [pem_pkg::CFG_DATA_W-1:0] cfg_data
);
    import pem_pkg::*;

    logic en;
    logic unit_degrees_reg;
    logic [15:0] clamp_tol_reg;

    // pipeline advances whenever the output slot is free or being taken
    assign en        = !m_tvalid || m_tready;
    assign s_tready  = en;
    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            unit_degrees_reg <= 1'b1;
            clamp_tol_reg    <= TOL_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_UNIT_DEGREES: unit_degrees_reg <= cfg_data[0];
                CFG_CLAMP_TOL:    clamp_tol_reg    <= cfg_data;
                default:          ;
            endcase
        end
    end

    // ---------------- unpack ----------------
    logic signed [ROT_W-1:0]   ra [3][3];
    logic signed [ROT_W-1:0]   rb [3][3];
    logic signed [TRANS_W-1:0] ta [3];
    logic signed [TRANS_W-1:0] tb [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                ra[i][k] = s_tdata[i * ROW_W + k * ROT_W +: ROT_W];
                rb[i][k] = s_tdata[(3 + i) * ROW_W + k * ROT_W +: ROT_W];
            end
            ta[i] = s_tdata[6 * ROW_W + i * TRANS_W +: TRANS_W];
            tb[i] = s_tdata[6 * ROW_W + TVEC_W + i * TRANS_W +: TRANS_W];
        end
    end

    // ---------------- stage 1: products ----------------
    logic v1_reg;
    logic signed [PT_W-1:0]    s1_pt_reg [3][3];
    logic signed [PR_W-1:0]    s1_pr_reg [3][3];
    logic signed [TRANS_W-1:0] s1_ta_reg [3];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    s1_pt_reg[i][k] <= ra[i][k] * tb[k];
                    s1_pr_reg[i][k] <= ra[i][k] * rb[k][i];
                end
                s1_ta_reg[i] <= ta[i];
            end
        end
    end

    // ---------------- stage 2: sums ----------------
    logic v2_reg;
    logic signed [P_W-1:0]  s2_p_reg [3];
    logic signed [TR_W-1:0] s2_trace_reg;
    logic signed [P_W-1:0]  p_next [3];
    logic signed [TR_W-1:0] trace_next;

    always_comb
    begin
        trace_next = '0;
        for (int i = 0; i < 3; i++)
        begin
            p_next[i] = P_W'(s1_ta_reg[i]) <<< ROT_FRAC_BITS;
            for (int k = 0; k < 3; k++)
            begin
                p_next[i]  = p_next[i] + P_W'(s1_pt_reg[i][k]);
                trace_next = trace_next + TR_W'(s1_pr_reg[i][k]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_p_reg     <= p_next;
            s2_trace_reg <= trace_next;
        end
    end

    // ---------------- stage 3: rounding and cosine range check ----------------
    logic v3_reg;
    logic signed [Q_W-1:0] s3_q_reg [3];
    logic [M_W-1:0]        s3_m_reg;
    side_t                 s3_side_reg;
    logic signed [P_W-1:0] p_rnd [3];
    logic signed [D_W-1:0] d_val;
    logic [D_W-1:0]        one2;
    logic [D_W-1:0]        tol2;
    logic [D_W-1:0]        mag;
    logic [D_W-1:0]        m_full;
    side_t                 side3_next;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            p_rnd[i] = (s2_p_reg[i] + (P_W'(1) <<< (ROT_FRAC_BITS - 1))) >>> ROT_FRAC_BITS;
        end
        d_val  = D_W'(s2_trace_reg) - (D_W'(1) <<< (2 * ROT_FRAC_BITS));
        one2   = D_W'(1) << COS_FB;
        tol2   = D_W'(clamp_tol_reg) << TOL_SHL;
        mag    = d_val[D_W-1] ? D_W'(-d_val) : D_W'(d_val);
        m_full = (mag >> M_SHR) << M_SHL;

        side3_next        = '0;
        side3_next.status = ST_OK;
        side3_next.src    = SRC_CORDIC;
        side3_next.neg    = d_val[D_W-1];
        if (!d_val[D_W-1] && mag > one2)
        begin
            side3_next.src = SRC_ZERO;
            if (mag - one2 >= tol2)
                side3_next.status = ST_HIGH;
        end
        else if (d_val[D_W-1] && mag > one2)
        begin
            side3_next.src = SRC_PI;
            if (mag - one2 >= tol2)
            begin
                side3_next.src    = SRC_ZERO;
                side3_next.status = ST_LOW;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
                s3_q_reg[i] <= p_rnd[i][Q_W-1:0];
            s3_m_reg    <= (m_full > (D_W'(1) << 30)) ? M_W'(1) << 30 : m_full[M_W-1:0];
            s3_side_reg <= side3_next;
        end
    end

    // ---------------- stage 4: squares ----------------
    logic v4_reg;
    logic [SQ_W-1:0]  s4_sq_reg [3];
    logic [2*M_W-1:0] s4_msq_reg;
    logic [M_W-1:0]   s4_m_reg;
    side_t            s4_side_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
                s4_sq_reg[i] <= SQ_W'(s3_q_reg[i] * s3_q_reg[i]);
            s4_msq_reg  <= s3_m_reg * s3_m_reg;
            s4_m_reg    <= s3_m_reg;
            s4_side_reg <= s3_side_reg;
        end
    end

    // ---------------- stage 5: norm and radicand ----------------
    logic v5_reg;
    logic [63:0] s5_rad_reg;
    logic [M_W-1:0] s5_m_reg;
    side_t       s5_side_reg;
    logic [NSUM_W+NORM_SHL-1:0] norm_full;
    side_t       side5_next;

    always_comb
    begin
        norm_full = (NSUM_W+NORM_SHL)'(s4_sq_reg[0]) + (NSUM_W+NORM_SHL)'(s4_sq_reg[1])
                  + (NSUM_W+NORM_SHL)'(s4_sq_reg[2]);
        norm_full = (norm_full >> NORM_SHR) << NORM_SHL;
        side5_next = s4_side_reg;
        side5_next.norm = (norm_full > (NSUM_W+NORM_SHL)'({NORM_W{1'b1}}))
                        ? {NORM_W{1'b1}} : norm_full[NORM_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s5_rad_reg  <= (64'd1 << 60) - 64'(s4_msq_reg);
            s5_m_reg    <= s4_m_reg;
            s5_side_reg <= side5_next;
        end
    end

    // ---------------- square root, one result bit per stage ----------------
    logic [63:0]    sq_n_reg    [SQRT_STEPS+1];
    logic [63:0]    sq_res_reg  [SQRT_STEPS+1];
    logic [M_W-1:0] sq_m_reg    [SQRT_STEPS+1];
    side_t          sq_side_reg [SQRT_STEPS+1];
    logic           sq_v_reg    [SQRT_STEPS+1];

    assign sq_n_reg[0]    = s5_rad_reg;
    assign sq_res_reg[0]  = '0;
    assign sq_m_reg[0]    = s5_m_reg;
    assign sq_side_reg[0] = s5_side_reg;
    assign sq_v_reg[0]    = v5_reg;

    for (genvar j = 0; j < SQRT_STEPS; j++)
    begin : g_sqrt
        localparam logic [63:0] BIT = 64'd1 << (62 - 2 * j);
        logic [63:0] trial;
        assign trial = sq_res_reg[j] + BIT;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (sq_n_reg[j] >= trial)
                begin
                    sq_n_reg[j+1]   <= sq_n_reg[j] - trial;
                    sq_res_reg[j+1] <= (sq_res_reg[j] >> 1) + BIT;
                end
                else
                begin
                    sq_n_reg[j+1]   <= sq_n_reg[j];
                    sq_res_reg[j+1] <= sq_res_reg[j] >> 1;
                end
                sq_m_reg[j+1]    <= sq_m_reg[j];
                sq_side_reg[j+1] <= sq_side_reg[j];
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                sq_v_reg[j+1] <= 1'b0;
            else if (en)
                sq_v_reg[j+1] <= sq_v_reg[j];
        end
    end

    // ---------------- CORDIC vectoring, one rotation per stage ----------------
    logic signed [XY_W-1:0] co_x_reg    [CORDIC_STEPS+1];
    logic signed [XY_W-1:0] co_y_reg    [CORDIC_STEPS+1];
    logic signed [Z_W-1:0]  co_z_reg    [CORDIC_STEPS+1];
    side_t                  co_side_reg [CORDIC_STEPS+1];
    logic                   co_v_reg    [CORDIC_STEPS+1];

    assign co_x_reg[0]    = XY_W'(sq_m_reg[SQRT_STEPS]);
    assign co_y_reg[0]    = XY_W'(sq_res_reg[SQRT_STEPS][M_W-1:0]);
    assign co_z_reg[0]    = '0;
    assign co_side_reg[0] = sq_side_reg[SQRT_STEPS];
    assign co_v_reg[0]    = sq_v_reg[SQRT_STEPS];

    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_cordic
        logic signed [XY_W-1:0] dx;
        logic signed [XY_W-1:0] dy;
        assign dx = co_y_reg[i] >>> i;
        assign dy = co_x_reg[i] >>> i;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (!co_y_reg[i][XY_W-1])
                begin
                    co_x_reg[i+1] <= co_x_reg[i] + dx;
                    co_y_reg[i+1] <= co_y_reg[i] - dy;
                    co_z_reg[i+1] <= co_z_reg[i] + atan_q30(i);
                end
                else
                begin
                    co_x_reg[i+1] <= co_x_reg[i] - dx;
                    co_y_reg[i+1] <= co_y_reg[i] + dy;
                    co_z_reg[i+1] <= co_z_reg[i] - atan_q30(i);
                end
                co_side_reg[i+1] <= co_side_reg[i];
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                co_v_reg[i+1] <= 1'b0;
            else if (en)
                co_v_reg[i+1] <= co_v_reg[i];
        end
    end

    // ---------------- F1: clamp, mirror, special cases ----------------
    logic f1_v_reg;
    logic [Z_W-1:0] f1_u_reg;
    side_t          f1_side_reg;
    logic signed [Z_W-1:0] z_end;
    logic [Z_W-1:0] z_clamp;
    logic [Z_W-1:0] u_next;

    always_comb
    begin
        z_end = co_z_reg[CORDIC_STEPS];
        if (z_end[Z_W-1])
            z_clamp = '0;
        else if (z_end > $signed(HALF_PI_Q30))
            z_clamp = HALF_PI_Q30;
        else
            z_clamp = z_end;
        case (co_side_reg[CORDIC_STEPS].src)
            SRC_ZERO: u_next = '0;
            SRC_PI:   u_next = PI_Q30;
            default:  u_next = co_side_reg[CORDIC_STEPS].neg ? PI_Q30 - z_clamp : z_clamp;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f1_u_reg    <= u_next;
            f1_side_reg <= co_side_reg[CORDIC_STEPS];
        end
    end

    // ---------------- F2: unit scaling ----------------
    logic f2_v_reg;
    logic [Z_W+29:0] f2_prod_reg;
    logic [Z_W-1:0]  f2_u_reg;
    side_t           f2_side_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f2_prod_reg <= f1_u_reg * DEG_PER_RAD;
            f2_u_reg    <= f1_u_reg;
            f2_side_reg <= f1_side_reg;
        end
    end

    // ---------------- F3: rounding and output register ----------------
    logic [Z_W+29:0]     deg_r;
    logic [Z_W-1:0]      rad_r;
    logic [ANGLE_W-1:0]  angle_next;
    logic [ANGLE_W-1:0]  out_angle_reg;
    side_t               out_side_reg;

    always_comb
    begin
        deg_r = (f2_prod_reg + ((Z_W+30)'(1) << 37)) >> 38;
        rad_r = (f2_u_reg + (Z_W'(1) << 13)) >> 14;
        if (unit_degrees_reg)
            angle_next = (deg_r > (Z_W+30)'(ANGLE_MAX)) ? ANGLE_MAX : deg_r[ANGLE_W-1:0];
        else
            angle_next = (rad_r > Z_W'(ANGLE_MAX)) ? ANGLE_MAX : rad_r[ANGLE_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_angle_reg <= angle_next;
            out_side_reg  <= f2_side_reg;
        end
    end

    // valid bits of the front and back stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            v4_reg   <= 1'b0;
            v5_reg   <= 1'b0;
            f1_v_reg <= 1'b0;
            f2_v_reg <= 1'b0;
            m_tvalid <= 1'b0;
        end
        else if (en)
        begin
            v1_reg   <= s_tvalid;
            v2_reg   <= v1_reg;
            v3_reg   <= v2_reg;
            v4_reg   <= v3_reg;
            v5_reg   <= v4_reg;
            f1_v_reg <= co_v_reg[CORDIC_STEPS];
            f2_v_reg <= f1_v_reg;
            m_tvalid <= f2_v_reg;
        end
    end

    assign m_tdata = OUT_DATA_W'({out_side_reg.status, out_angle_reg, out_side_reg.norm});

endmodule

`default_nettype wire

[hw/rtl/pem_checker.sv]
// ----------------------------------------------------------------------------
// pem_checker
// Port-level assertions for the pose error metric, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module pem_checker (
    input wire logic                           clk,
    input wire logic                           rst_n,
    input wire logic                           s_tready,
    input wire logic                           m_tvalid,
    input wire logic                           m_tready,
    input wire logic [pem_pkg::OUT_DATA_W-1:0] m_tdata
);
    import pem_pkg::*;

    // an error status always comes with a zero angle
    a_err_zero_angle: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[65:64] != 2'd0) |-> (m_tdata[63:40] == 24'd0))
        else $error("angle not zero on error status");

    // angle at most ANGLE_MAX (180 degrees), status code never unused
    a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[63:40] <= ANGLE_MAX) && (m_tdata[65:64] != 2'd3))
        else $error("result out of range");

    // an empty output slot always lets a request in
    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with free output");

    // a held result stays put
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

endmodule

bind pose_error_metric pem_checker u_pem_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

[bench/pose_error_metric_tb.sv]
// ----------------------------------------------------------------------------
// pose_error_metric_tb
// Self-checking bench for the pose error metric pipeline. Pose pairs go in
// on the input stream with random gaps; a local fixed-point predictor works
// out the squared translation norm, angle and status of each request, and
// every output request is checked against the oldest pending prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module pose_error_metric_tb;

    import pem_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int  CYCLE_LIMIT = 400000;
    localparam int  SETTLE      = 100;   // longer than the pipeline latency
    localparam real PI_R        = 3.14159265358979;

    // arctangent of 2^-i, Q30 radians
    localparam longint ATAN_Q30 [30] = '{
        843314857, 497837829, 263043837, 133525159, 67021687,
        33543516, 16775851, 8388437, 4194283, 2097149,
        1048576, 524288, 262144, 131072, 65536,
        32768, 16384, 8192, 4096, 2048,
        1024, 512, 256, 128, 64,
        32, 16, 8, 4, 2
    };
    localparam longint PI_Z      = 64'd3373259426;
    localparam longint HALF_PI_Z = 64'd1686629713;

    typedef struct {
        logic [ROW_W-1:0]  row [6];   // rot_a rows 0..2, then rot_b rows 0..2
        logic [TVEC_W-1:0] tvec [2];  // trans_a, trans_b
    } pose_pair_t;

    typedef struct {
        logic [NORM_W-1:0]  norm;
        logic [ANGLE_W-1:0] angle;
        status_t            status;
    } pose_error_t;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // predictor copy of the registers
    bit          deg_mode;
    logic [15:0] cos_tol;

    pose_error_t pending_errors [$];
    int          n_sent;
    int          n_checked;
    int          n_fail;
    int          n_status [3];
    int          cycles;

    // traffic shaping
    bit tx_idle_en;
    bit rx_idle_en;
    int rx_hold_len;

    pose_error_metric u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // ------------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------------
    function automatic longint entry_at(logic [63:0] f, int k, int w);
        logic [63:0] v;
        v = (f >> (k * w)) & ((64'd1 << w) - 64'd1);
        if (v[w-1])
            return longint'(v) - (longint'(1) << w);
        return longint'(v);
    endfunction

    // acos of d / 2^33 in Q30 radians, by square root and CORDIC vectoring
    function automatic longint acos_q30(longint d);
        bit     neg;
        longint mag, m, n, root, b, x, y, z, dx, dy;
        neg = d < 0;
        mag = neg ? -d : d;
        m   = mag >>> (2 * ROT_FRAC_BITS + 1 - 30);
        if (m > (longint'(1) << 30))
            m = longint'(1) << 30;
        n    = (longint'(1) << 60) - m * m;
        root = 0;
        b    = longint'(1) << 62;
        while (b > n)
            b = b >> 2;
        while (b != 0)
        begin
            if (n >= root + b)
            begin
                n    = n - (root + b);
                root = (root >> 1) + b;
            end
            else
                root = root >> 1;
            b = b >> 2;
        end
        x = m;
        y = root;
        z = 0;
        for (int i = 0; i < 30; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0)
            begin
                x += dx; y -= dy; z += ATAN_Q30[i];
            end
            else
            begin
                x -= dx; y += dy; z -= ATAN_Q30[i];
            end
        end
        if (z < 0)
            z = 0;
        if (z > HALF_PI_Z)
            z = HALF_PI_Z;
        return neg ? PI_Z - z : z;
    endfunction

    function automatic logic [ANGLE_W-1:0] angle_in_unit(longint z);
        logic [63:0] u, r;
        u = (z < 0) ? 64'd0 : 64'(z);
        if (deg_mode)
            r = (u * 64'd961263669 + (64'd1 << 37)) >> 38;
        else
            r = (u + (64'd1 << 13)) >> 14;
        if (r > 64'd11796480)
            r = 64'd11796480;
        return r[ANGLE_W-1:0];
    endfunction

    function automatic pose_error_t pose_error(pose_pair_t pp);
        pose_error_t res;
        longint      ra [3][3];
        longint      rb [3][3];
        longint      ta [3];
        longint      tb [3];
        longint      tr, p, q, d, one2, tol2;
        logic [63:0] sum;
        for (int i = 0; i < 3; i++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                ra[i][k] = entry_at(64'(pp.row[i]), k, ROT_W);
                rb[i][k] = entry_at(64'(pp.row[3+i]), k, ROT_W);
            end
            ta[i] = entry_at(64'(pp.tvec[0]), i, TRANS_W);
            tb[i] = entry_at(64'(pp.tvec[1]), i, TRANS_W);
        end
        tr  = 0;
        sum = 0;
        for (int i = 0; i < 3; i++)
        begin
            p = ta[i] <<< ROT_FRAC_BITS;
            for (int k = 0; k < 3; k++)
            begin
                p  += ra[i][k] * tb[k];
                tr += ra[i][k] * rb[k][i];
            end
            q = (p + (longint'(1) << (ROT_FRAC_BITS - 1))) >>> ROT_FRAC_BITS;
            sum += 64'(q * q);
        end
        // Q24 squares already carry 24 fraction bits
        res.norm   = (sum > 64'hFF_FFFF_FFFF) ? '1 : sum[NORM_W-1:0];
        res.angle  = '0;
        res.status = ST_OK;
        d    = tr - (longint'(1) << (2 * ROT_FRAC_BITS));
        one2 = longint'(1) << (2 * ROT_FRAC_BITS + 1);
        tol2 = longint'(cos_tol) << (2 * ROT_FRAC_BITS + 1 - 16);
        if (d > one2)
        begin
            if (d - one2 >= tol2)
                res.status = ST_HIGH;
        end
        else if (d < -one2)
        begin
            if (-d - one2 < tol2)
                res.angle = angle_in_unit(PI_Z);
            else
                res.status = ST_LOW;
        end
        else
            res.angle = angle_in_unit(acos_q30(d));
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    function automatic logic [ROW_W-1:0] row_of(longint e0, longint e1, longint e2);
        logic [ROT_W-1:0] a, b, c;
        a = e0[ROT_W-1:0];
        b = e1[ROT_W-1:0];
        c = e2[ROT_W-1:0];
        return {c, b, a};
    endfunction

    function automatic logic [TVEC_W-1:0] tvec_of(longint x, longint y, longint z);
        logic [TRANS_W-1:0] a, b, c;
        a = x[TRANS_W-1:0];
        b = y[TRANS_W-1:0];
        c = z[TRANS_W-1:0];
        return {c, b, a};
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // diagonal rotations, one per pose; translations given
    function automatic pose_pair_t diag_pair(longint a0, longint a1, longint a2,
                                             longint b0, longint b1, longint b2,
                                             logic [TVEC_W-1:0] tva,
                                             logic [TVEC_W-1:0] tvb);
        pose_pair_t pp;
        pp.row[0]  = row_of(a0, 0, 0);
        pp.row[1]  = row_of(0, a1, 0);
        pp.row[2]  = row_of(0, 0, a2);
        pp.row[3]  = row_of(b0, 0, 0);
        pp.row[4]  = row_of(0, b1, 0);
        pp.row[5]  = row_of(0, 0, b2);
        pp.tvec[0] = tva;
        pp.tvec[1] = tvb;
        return pp;
    endfunction

    // rotation about a random axis, exact reals
    task automatic rand_rotation(output real m [3][3], input real ang);
        real k [3];
        real nrm, c, s;
        do
        begin
            for (int i = 0; i < 3; i++)
                k[i] = real'($urandom_range(2000)) - 1000.0;
            nrm = $sqrt(k[0] * k[0] + k[1] * k[1] + k[2] * k[2]);
        end
        while (nrm < 1.0);
        for (int i = 0; i < 3; i++)
            k[i] = k[i] / nrm;
        c = $cos(ang);
        s = $sin(ang);
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                m[i][j] = (1.0 - c) * k[i] * k[j] + ((i == j) ? c : 0.0);
        m[0][1] -= s * k[2]; m[1][0] += s * k[2];
        m[0][2] += s * k[1]; m[2][0] -= s * k[1];
        m[1][2] -= s * k[0]; m[2][1] += s * k[0];
    endtask

    function automatic logic [TVEC_W-1:0] rand_tvec();
        logic [63:0] r;
        r = rand64();
        // mostly modest offsets, sometimes the full range
        if ($urandom_range(3) == 0)
            return r[TVEC_W-1:0];
        return tvec_of($signed(r[13:0]), $signed(r[33:20]), $signed(r[53:40]));
    endfunction

    // kind 0: two arbitrary rotations; 1: composed rotation near identity;
    // 2: near a half turn; 3: raw bits
    task automatic build_pair(output pose_pair_t pp, input int kind);
        real    r [3][3];
        longint a, b;
        longint flip [3];
        int     noise;
        if (kind == 3)
        begin
            for (int i = 0; i < 6; i++)
                pp.row[i] = ROW_W'(rand64());
            pp.tvec[0] = TVEC_W'(rand64());
            pp.tvec[1] = TVEC_W'(rand64());
            return;
        end
        noise = ($urandom_range(1) == 0) ? 3 : 200;
        if (kind == 2)
            flip = '{1, -1, -1};
        else
            flip = '{1, 1, 1};
        rand_rotation(r, real'($urandom_range(100000)) * PI_R / 100000.0);
        for (int i = 0; i < 3; i++)
            pp.row[i] = row_of(longint'(r[i][0] * 65536.0), longint'(r[i][1] * 65536.0),
                               longint'(r[i][2] * 65536.0));
        if (kind == 0)
            rand_rotation(r, real'($urandom_range(100000)) * PI_R / 100000.0);
        for (int i = 0; i < 3; i++)
        begin
            longint e [3];
            for (int j = 0; j < 3; j++)
            begin
                // kinds 1, 2 transpose the first pose; kind 2 flips columns
                a    = (kind == 0) ? longint'(r[i][j] * 65536.0)
                                   : longint'(r[j][i] * 65536.0) * flip[j];
                b    = (kind != 0 && i == j) ? $urandom_range(2 * noise) - noise : 0;
                e[j] = a + b;
            end
            pp.row[3+i] = row_of(e[0], e[1], e[2]);
        end
        pp.tvec[0] = rand_tvec();
        pp.tvec[1] = rand_tvec();
    endtask

    // ------------------------------------------------------------------------
    // driving
    // ------------------------------------------------------------------------
    task automatic send_pair(pose_pair_t pp);
        s_tdata  <= IN_DATA_W'({pp.tvec[1], pp.tvec[0], pp.row[5], pp.row[4],
                                pp.row[3], pp.row[2], pp.row[1], pp.row[0]});
        s_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        pending_errors.insert(pending_errors.size(), pose_error(pp));
        n_sent++;
        if (tx_idle_en && $urandom_range(99) < 37)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    task automatic end_burst();
        s_tvalid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic wait_drained();
        while (pending_errors.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        wait_drained();
        repeat (SETTLE) @(posedge clk);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_UNIT_DEGREES)
            deg_mode = val[0];
        else
            cos_tol = val;
        @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // receiver: random stalls, or a long hold when asked
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rx_hold_len > 0)
        begin
            m_tready    <= 1'b0;
            rx_hold_len <= rx_hold_len - 1;
        end
        else
            m_tready <= !(rx_idle_en && $urandom_range(99) < 37);
    end

    // result checker
    always @(posedge clk)
    begin
        pose_error_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_errors.size() == 0)
            begin
                $error("result with no request pending: %h", m_tdata);
                n_fail++;
            end
            else
            begin
                want = pending_errors.pop_front();
                n_checked++;
                n_status[want.status]++;
                if (m_tdata[NORM_W-1:0] !== want.norm)
                begin
                    $error("trans_sq_norm expected %h got %h", want.norm, m_tdata[NORM_W-1:0]);
                    n_fail++;
                end
                if (m_tdata[NORM_W +: ANGLE_W] !== want.angle)
                begin
                    $error("rot_angle expected %0d got %0d", want.angle,
                           m_tdata[NORM_W +: ANGLE_W]);
                    n_fail++;
                end
                if (m_tdata[NORM_W+ANGLE_W +: STATUS_W] !== want.status)
                begin
                    $error("status expected %0d got %0d", want.status,
                           m_tdata[NORM_W+ANGLE_W +: STATUS_W]);
                    n_fail++;
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("TEST FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------
    task automatic test_directed();
        localparam longint U = 65536;
        logic [TVEC_W-1:0] tmin, tmax;
        pose_pair_t        pp;
        tmin = tvec_of(-(1 << 19), -(1 << 19), -(1 << 19));
        tmax = tvec_of((1 << 19) - 1, (1 << 19) - 1, (1 << 19) - 1);
        // identity, cosine exactly one and exactly minus one
        send_pair(diag_pair(U, U, U, U, U, U, '0, '0));
        send_pair(diag_pair(U, -U, -U, U, U, U, tmax, '0));
        // just above one, and right at the tolerance
        send_pair(diag_pair(U, U, U, U + 1, U, U, '0, tmax));
        send_pair(diag_pair(U, U, U, U + 131, U, U, tmin, tmin));
        send_pair(diag_pair(U, U, U, U + 132, U, U, tmax, tmax));
        send_pair(diag_pair(U, U, U, 2 * U - 1, 2 * U - 1, 2 * U - 1, '0, '0));
        // just below minus one, and right at the tolerance
        send_pair(diag_pair(U, -U, -U, U, U + 1, U, '0, '0));
        send_pair(diag_pair(U, -U, -U, U, U + 131, U, tmin, tmax));
        send_pair(diag_pair(U, -U, -U, U, U + 132, U, '0, tmin));
        send_pair(diag_pair(-2 * U, -2 * U, -2 * U, 2 * U - 1, 2 * U - 1, 2 * U - 1,
                            tmax, tmin));
        // quarter turn about z
        pp = diag_pair(0, 0, U, 0, 0, U, tmin, tmax);
        pp.row[0] = row_of(0, -U, 0);
        pp.row[1] = row_of(U, 0, 0);
        send_pair(pp);
        // all zeros, all ones, large norm
        for (int i = 0; i < 6; i++)
            pp.row[i] = '0;
        pp.tvec[0] = '0;
        pp.tvec[1] = '0;
        send_pair(pp);
        for (int i = 0; i < 6; i++)
            pp.row[i] = '1;
        pp.tvec[0] = '1;
        pp.tvec[1] = '1;
        send_pair(pp);
        send_pair(diag_pair(-2 * U, -2 * U, -2 * U, U, U, U, tmin, tmin));
        end_burst();
    endtask

    task automatic test_random_phase(int count);
        pose_pair_t pp;
        int         sel;
        for (int n = 0; n < count; n++)
        begin
            sel = $urandom_range(99);
            build_pair(pp, (sel < 40) ? 0 : (sel < 60) ? 1 : (sel < 80) ? 2 : 3);
            send_pair(pp);
        end
        end_burst();
    endtask

    // receiver stalls long while the sender keeps pushing
    task automatic test_backpressure();
        pose_pair_t pp;
        tx_idle_en  = 1'b0;
        rx_hold_len = 400;
        for (int n = 0; n < 150; n++)
        begin
            build_pair(pp, n % 4);
            send_pair(pp);
        end
        end_burst();
        // sender pauses until everything is back
        wait_drained();
        tx_idle_en = 1'b1;
    endtask

    task automatic test_config_sweep();
        // no idling at all on this first phase
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        write_reg(CFG_UNIT_DEGREES, '0);
        write_reg(CFG_CLAMP_TOL, '0);
        test_random_phase(330);
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        write_reg(CFG_UNIT_DEGREES, 16'd1);
        write_reg(CFG_CLAMP_TOL, 16'hFFFF);
        test_random_phase(330);
        write_reg(CFG_UNIT_DEGREES, '0);
        write_reg(CFG_CLAMP_TOL, 16'($urandom_range(1, 400)));
        test_random_phase(330);
        write_reg(CFG_UNIT_DEGREES, 16'($urandom) | 16'd1);
        write_reg(CFG_CLAMP_TOL, 16'($urandom));
        test_random_phase(330);
        write_reg(CFG_CLAMP_TOL, 16'd66);
        test_random_phase(330);
    endtask

    initial
    begin
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        m_tready    = 1'b0;
        cfg_valid   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        deg_mode    = 1'b1;
        cos_tol     = TOL_RESET;
        tx_idle_en  = 1'b1;
        rx_idle_en  = 1'b1;
        rx_hold_len = 0;
        n_sent      = 0;
        n_checked   = 0;
        n_fail      = 0;
        n_status    = '{0, 0, 0};
        cycles      = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_backpressure();
        test_config_sweep();

        wait_drained();
        repeat (SETTLE) @(posedge clk);
        $display("%0d pose pairs sent, %0d results checked in %0d cycles", n_sent,
                 n_checked, cycles);
        $display("status ok/high/low: %0d/%0d/%0d over degree and radian settings",
                 n_status[0], n_status[1], n_status[2]);
        if (n_fail == 0 && pending_errors.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

`default_nettype wire
